[rtl/sida_pkg.sv]
`default_nettype none
package sida_pkg;

   // ASCII codes used in the text
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // field and internal widths
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned WIDE_W  = 34;  // holds 9 * 10^9
   localparam int unsigned POS_W   = 4;   // digit position 0..9
   localparam int unsigned DIGIT_W = 4;

   // controller to datapath
   typedef struct packed {
      logic load;   // take a new value, form its magnitude
      logic scan;   // find the leading digit position, send '-' if negative
      logic digit;  // send the digit at the current position
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic neg;       // value is negative
      logic last_pos;  // current position is the units digit
      logic out_free;  // output register can take a beat this cycle
   } status_type;

   // 10^p for the ten digit positions of a 32-bit magnitude
   function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] p);
      logic [WIDE_W-1:0] r;
      case (p)
         4'd0: r = 34'd1;
         4'd1: r = 34'd10;
         4'd2: r = 34'd100;
         4'd3: r = 34'd1000;
         4'd4: r = 34'd10000;
         4'd5: r = 34'd100000;
         4'd6: r = 34'd1000000;
         4'd7: r = 34'd10000000;
         4'd8: r = 34'd100000000;
         4'd9: r = 34'd1000000000;
         default: r = 34'd0;
      endcase
      return r;
   endfunction

   // d * 10^p; d is a constant at every call site, so this folds to a table
   function automatic logic [WIDE_W-1:0] dec_mult(input logic [POS_W-1:0] p,
                                                  input logic [DIGIT_W-1:0] d);
      return WIDE_W'(pow10(p) * WIDE_W'(d));
   endfunction

endpackage
`default_nettype wire

[rtl/sida_ctrl.sv]
`default_nettype none
module sida_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire sida_pkg::status_type status,
   output sida_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DIGIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // the sign beat needs a free output slot
            if (!status.neg || status.out_free) begin
               cmd.scan = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.digit = 1'b1;
               if (status.last_pos) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/sida_datapath.sv]
`default_nettype none
module sida_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [sida_pkg::VALUE_W-1:0] value,
   input  wire sida_pkg::cmd_type                   cmd,
   output sida_pkg::status_type                     status,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [sida_pkg::CHAR_W-1:0]              character,
   output logic                                     last_char
);

   logic [sida_pkg::VALUE_W-1:0] mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [sida_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [sida_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic                         last_ff, last_in;
   logic                         valid_ff, valid_in;

   logic [sida_pkg::WIDE_W-1:0]  mag_wide;
   logic [sida_pkg::POS_W-1:0]   lead_pos;
   logic [sida_pkg::DIGIT_W-1:0] digit;
   logic [sida_pkg::WIDE_W-1:0]  digit_sub;
   logic                         out_free;

   assign mag_wide = {2'b00, mag_ff};
   assign out_free = !valid_ff || rsp_tready;

   // leading digit position: how many powers 10..10^9 the magnitude reaches
   always_comb begin
      lead_pos = '0;
      for (int k = 1; k < 10; k++) begin
         if (mag_wide >= sida_pkg::pow10(sida_pkg::POS_W'(k))) begin
            lead_pos = lead_pos + 1'b1;
         end
      end
   end

   // digit at pos_ff: largest d with d * 10^pos not above the magnitude
   always_comb begin
      digit     = '0;
      digit_sub = '0;
      for (int d = 1; d < 10; d++) begin
         if (mag_wide >= sida_pkg::dec_mult(pos_ff, sida_pkg::DIGIT_W'(d))) begin
            digit     = sida_pkg::DIGIT_W'(d);
            digit_sub = sida_pkg::dec_mult(pos_ff, sida_pkg::DIGIT_W'(d));
         end
      end
   end

   // magnitude, sign and position
   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      pos_in = pos_ff;
      if (cmd.load) begin
         neg_in = value[sida_pkg::VALUE_W-1];
         mag_in = value[sida_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      end else if (cmd.scan) begin
         pos_in = lead_pos;
      end else if (cmd.digit) begin
         mag_in = mag_ff - digit_sub[sida_pkg::VALUE_W-1:0];
         pos_in = pos_ff - 1'b1;
      end
   end

   // output register
   always_comb begin
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      if (cmd.scan && neg_ff) begin
         char_in  = sida_pkg::CHAR_MINUS;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end else if (cmd.digit) begin
         char_in  = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digit);
         last_in  = (pos_ff == '0);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.neg      = neg_ff;
   assign status.last_pos = (pos_ff == '0);
   assign status.out_free = out_free;

   assign rsp_tvalid = valid_ff;
   assign character  = char_ff;
   assign last_char  = last_ff;

endmodule
`default_nettype wire

[rtl/signed_int_to_decimal_ascii.sv]
// Converts one signed 32-bit value per input beat into its decimal text, one
// ASCII character per output beat: '-' first for a negative value, then the
// digits from the most significant down with no leading zeros, tlast on the
// final digit. In turn, the block takes the value and forms its magnitude,
// finds the leading digit position and sends the sign, then sends the digits
// one by one; the sign and digit steps wait while the output register is full.
// Each digit step compares the
// magnitude against the nine multiples of the current power of ten and
// subtracts the chosen one. The input is taken again as soon as the last digit
// sits in the output register, while that beat still waits to be taken.
`default_nettype none
module signed_int_to_decimal_ascii (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic signed [sida_pkg::VALUE_W-1:0] req_tdata,   // [31:0] value
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [sida_pkg::CHAR_W-1:0]              rsp_tdata,   // [7:0] character
   output logic                                     rsp_tlast    // last_char
);

   sida_pkg::cmd_type    cmd;
   sida_pkg::status_type status;

   sida_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sida_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .character  (rsp_tdata),
      .last_char  (rsp_tlast)
   );

`ifndef SYNTH
   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.digit}))
      else $error("more than one datapath command at once");

   // busy right after a value is taken
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready)
      else $error("input ready while a value is in work");

   // the units digit returns the block to idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.digit && status.last_pos) |=> (req_tready && rsp_tvalid && rsp_tlast))
      else $error("no idle or no tlast after the units digit");

   // the sign never closes a text
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == sida_pkg::CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign flagged as last character");
`endif

endmodule
`default_nettype wire

[test/signed_int_to_decimal_ascii_check.sv]
`default_nettype none
module signed_int_to_decimal_ascii_check (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   input  wire logic signed [sida_pkg::VALUE_W-1:0] req_tdata,    // [31:0] value
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic [sida_pkg::CHAR_W-1:0]         rsp_tdata,    // [7:0] character
   input  wire logic                                rsp_tlast,    // last_char
   output int                                       error_count,
   output int                                       chars_due
);

   localparam logic [sida_pkg::VALUE_W-1:0] RADIX      = 32'd10;
   localparam int                           MAX_DIGITS = 10;

   typedef struct packed {
      logic [sida_pkg::CHAR_W-1:0] character;
      logic                        last_char;
   } text_beat_type;

   // characters still owed by the block, oldest first
   text_beat_type text_due[$];

   // push the decimal text of one value onto the queue of owed characters
   function automatic void spell_value(input logic [sida_pkg::VALUE_W-1:0] raw);
      logic [sida_pkg::VALUE_W-1:0] mag;
      logic [3:0]                   digit_buf [MAX_DIGITS];
      int                           count;
      text_beat_type                beat;
      // two's complement magnitude; the most negative value maps to 2^31
      mag   = raw[sida_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
      count = 0;
      do begin
         digit_buf[count] = 4'(mag % RADIX);
         mag              = mag / RADIX;
         count++;
      end while (mag != 0 && count < MAX_DIGITS);
      if (raw[sida_pkg::VALUE_W-1]) begin
         beat.character = sida_pkg::CHAR_MINUS;
         beat.last_char = 1'b0;
         text_due.push_back(beat);
      end
      for (int i = count - 1; i >= 0; i--) begin
         beat.character = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digit_buf[i]);
         beat.last_char = (i == 0);
         text_due.push_back(beat);
      end
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      text_beat_type want;
      if (reset) begin
         text_due.delete();
         error_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            spell_value(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (text_due.size() == 0) begin
               $error("unexpected beat: character %0d last_char %0b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = text_due.pop_front();
               if (rsp_tdata !== want.character) begin
                  $error("character: expected %0d, actual %0d", want.character, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last_char) begin
                  $error("last_char: expected %0b, actual %0b", want.last_char, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
      chars_due = text_due.size();
   end

endmodule
`default_nettype wire

[test/signed_int_to_decimal_ascii_test.sv]
`default_nettype none
module signed_int_to_decimal_ascii_test;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 360;
   localparam int IDLE_LIMIT   = 3000;  // well above the long hold-off
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_START   = 800;
   localparam int HOLD_CYCLES  = 400;
   localparam int NUM_DIRECTED = 20;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic signed [sida_pkg::VALUE_W-1:0] req_tdata;    // [31:0] value
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [sida_pkg::CHAR_W-1:0]         rsp_tdata;    // [7:0] character
   logic                                rsp_tlast;    // last_char
   int                                  error_count;
   int                                  chars_due;
   int                                  burst_left;
   int                                  idle_cycles;

   // edges of the range, digit counts 1-3, 5, 7, 9 and 10, zeros inside the text
   logic signed [sida_pkg::VALUE_W-1:0] directed_values [0:NUM_DIRECTED-1] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      32'sd2147483647, 32'sh80000000, -32'sd2147483647, 32'sd1000000000,
      32'sd999999999, -32'sd999999999, 32'sd1000000009, -32'sd5,
      32'sd123456789, -32'sd1000000000, 32'sd4294967, -32'sd70000
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   signed_int_to_decimal_ascii u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   signed_int_to_decimal_ascii_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .chars_due   (chars_due)
   );

   // mostly a chosen digit count and sign, some raw words and small values
   function automatic logic signed [sida_pkg::VALUE_W-1:0] random_value();
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mag;
      longint unsigned r;
      int              kind;
      int              n;
      logic            neg;
      kind = $urandom_range(0, 9);
      neg  = 1'($urandom_range(0, 1));
      if (kind < 2) begin
         return $urandom;
      end else if (kind == 2) begin
         return $signed(32'($urandom_range(0, 40))) - 32'sd20;
      end
      n  = $urandom_range(1, 10);
      lo = 1;
      for (int i = 1; i < n; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (n == 1) lo = 0;
      if (neg && hi > 64'd2147483648) hi = 64'd2147483648;
      if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
      r   = {$urandom, $urandom};
      mag = lo + r % (hi - lo + 1);
      return neg ? -$signed(32'(mag)) : $signed(32'(mag));
   endfunction

   // offer one value in bursts with random gaps, hold until it is taken
   task automatic send_value(input logic signed [sida_pkg::VALUE_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
      req_tvalid = 1'b1;
      req_tdata  = v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // receiver: stall patterns that change now and then, one long hold-off
   initial begin
      int cycle;
      int mode;
      int mode_left;
      int hold_left;
      rsp_tready = 1'b0;
      cycle      = 0;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle == HOLD_START) hold_left = HOLD_CYCLES;
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 256);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 1) == 0);
               2: rsp_tready = ($urandom_range(0, 4) != 0);
               default: rsp_tready = ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      burst_left  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++) send_value(directed_values[i]);
      repeat (RANDOM_ITEMS) send_value(random_value());
      req_tvalid = 1'b0;
      while (chars_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

[signed_int_to_decimal_ascii.f]
rtl/sida_pkg.sv
rtl/sida_ctrl.sv
rtl/sida_datapath.sv
rtl/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_check.sv
test/signed_int_to_decimal_ascii_test.sv
